[hw/rtl/lfu_pkg.sv]
// Shared types, constants and helpers for the LFU cache store.
package lfu_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int USES_W  = 32;
    localparam int STAMP_W = 64;
    localparam int CAP_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [USES_W-1:0] USES_MAX   = 32'hFFFF_FFFF;
    localparam logic [USES_W-1:0] USES_FIRST = 32'd1;

    // Register index taken from the word address (paddr[2]).
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [USES_W-1:0]  uses;
        logic [STAMP_W-1:0] stamp;
    } slot_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] hit_data;
        logic [USES_W-1:0] hit_uses;
        logic [KEY_W-1:0]  min_key;
    } scan_status_t;

    function automatic logic [USES_W-1:0] sat_inc(input logic [USES_W-1:0] uses);
        logic [USES_W-1:0] result;
        if (uses == USES_MAX)
        begin
            result = uses;
        end
        else
        begin
            result = uses + USES_FIRST;
        end
        return result;
    endfunction

endpackage

[hw/rtl/lfu_slot_mem.sv]
// Slot memory: one write port and one registered read port.
module lfu_slot_mem #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output lfu_pkg::slot_t      rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  lfu_pkg::slot_t      wr_data
);
    import lfu_pkg::*;

    slot_t mem [ENTRIES];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/lfu_scan.sv]
// Shared compare unit: key match and running minimum of (uses, stamp), one slot per cycle.
module lfu_scan #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic                    cmp_valid,
    input  logic [IDX_W-1:0]        cmp_idx,
    input  lfu_pkg::slot_t          entry,
    input  logic [31:0]             lookup_key,
    output lfu_pkg::scan_status_t   status,
    output logic [IDX_W-1:0]        hit_idx,
    output logic [IDX_W-1:0]        min_idx
);
    import lfu_pkg::*;

    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [DATA_W-1:0]  hit_data_reg;
    logic [USES_W-1:0]  hit_uses_reg;
    logic               min_set_reg;
    logic [IDX_W-1:0]   min_idx_reg;
    logic [USES_W-1:0]  min_uses_reg;
    logic [STAMP_W-1:0] min_stamp_reg;
    logic [KEY_W-1:0]   min_key_reg;

    logic key_eq;
    logic rarer;

    assign key_eq = (entry.key == lookup_key);
    // Strictly lower only, so the lowest index wins on equal pairs.
    assign rarer  = ({entry.uses, entry.stamp} < {min_uses_reg, min_stamp_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg     <= 1'b0;
            min_set_reg <= 1'b0;
        end
        else if (clear)
        begin
            hit_reg     <= 1'b0;
            min_set_reg <= 1'b0;
        end
        else if (cmp_valid)
        begin
            if (key_eq)
            begin
                hit_reg <= 1'b1;
            end
            min_set_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_valid && !clear)
        begin
            if (key_eq && !hit_reg)
            begin
                hit_idx_reg  <= cmp_idx;
                hit_data_reg <= entry.data;
                hit_uses_reg <= entry.uses;
            end
            if (!min_set_reg || rarer)
            begin
                min_idx_reg   <= cmp_idx;
                min_uses_reg  <= entry.uses;
                min_stamp_reg <= entry.stamp;
                min_key_reg   <= entry.key;
            end
        end
    end

    assign status.hit      = hit_reg;
    assign status.hit_data = hit_data_reg;
    assign status.hit_uses = hit_uses_reg;
    assign status.min_key  = min_key_reg;
    assign hit_idx         = hit_idx_reg;
    assign min_idx         = min_idx_reg;

endmodule

[hw/rtl/lfu_cache_store.sv]
// LFU key-value store: one compare unit walks the occupied slots, then one write back.
// The walk reads one slot per cycle through the single memory read port; a new item is
// accepted only once the previous item has been written back. The result beat is registered
// at write-back, which waits while an earlier result is still held by out_stall.
// Reset clears the fill count, the tick counter and the handshake state and sets capacity
// to 16; slots at or above the fill count are empty, so the memory needs no clearing.
module lfu_cache_store #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lfu_pkg::PADDR_W-1:0]  paddr,
    input  logic [lfu_pkg::PDATA_W-1:0]  pwdata,
    output logic [lfu_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic signed [31:0]           key,
    input  logic signed [31:0]           value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic signed [31:0]           read_value,
    output logic                         evicted,
    output logic signed [31:0]           evicted_key
);
    import lfu_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Configuration
    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    // Sequencer
    state_t state_reg;
    state_t state_next;

    logic               accept;
    logic               rd_en;
    logic               commit;

    logic               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [DATA_W-1:0]  value_reg;
    logic [CNT_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   cap_eff;
    logic [CNT_W-1:0]   occ_reg;
    logic [CNT_W-1:0]   iss_cnt_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [STAMP_W-1:0] tick_reg;

    slot_t              rd_data;
    scan_status_t       status;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   min_idx;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_t              wr_data;
    logic               occ_inc;
    logic               ev_next;
    logic [KEY_W-1:0]   evk_next;
    logic [DATA_W-1:0]  rd_value_next;

    logic               out_valid_reg;
    logic               found_reg;
    logic [DATA_W-1:0]  read_value_reg;
    logic               evicted_reg;
    logic [KEY_W-1:0]   evicted_key_reg;

    assign cap_eff = (32'(capacity_reg) > 32'(ENTRIES)) ? CNT_W'(ENTRIES)
                                                        : CNT_W'(capacity_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // The last compare lands in the scan unit at the same edge.
                if (iss_cnt_reg == occ_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en = (iss_cnt_reg != occ_reg);
            end
            ST_DONE:
            begin
                commit = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_cnt_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            occ_reg       <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= rd_en;
            if (accept)
            begin
                iss_cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            end
            if (wr_en)
            begin
                tick_reg <= tick_reg + 64'd1;
            end
            if (commit && occ_inc)
            begin
                occ_reg <= occ_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            key_reg   <= key;
            value_reg <= value;
            cap_reg   <= cap_eff;
        end
        if (rd_en)
        begin
            cmp_idx_reg <= iss_cnt_reg[IDX_W-1:0];
        end
    end

    lfu_slot_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (iss_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lfu_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (accept),
        .cmp_valid  (cmp_valid_reg),
        .cmp_idx    (cmp_idx_reg),
        .entry      (rd_data),
        .lookup_key (key_reg),
        .status     (status),
        .hit_idx    (hit_idx),
        .min_idx    (min_idx)
    );

    // Write-back decision. Occupied slots are always 0 .. occupancy-1, so a fresh
    // slot is the one at the fill count and an eviction reuses the victim's slot.
    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = hit_idx;
        wr_data.key    = key_reg;
        wr_data.data   = value_reg;
        wr_data.uses   = sat_inc(status.hit_uses);
        wr_data.stamp  = tick_reg + 64'd1;
        occ_inc        = 1'b0;
        ev_next        = 1'b0;
        evk_next       = '0;
        rd_value_next  = '0;
        if (cmd_reg == CMD_GET)
        begin
            if (status.hit)
            begin
                rd_value_next = status.hit_data;
                wr_data.data  = status.hit_data;
                wr_en         = commit;
            end
            else
            begin
                rd_value_next = MISS_VALUE;
            end
        end
        else if (cap_reg != '0)
        begin
            wr_en = commit;
            if (!status.hit)
            begin
                wr_data.uses = USES_FIRST;
                if (occ_reg >= cap_reg)
                begin
                    wr_addr  = min_idx;
                    ev_next  = 1'b1;
                    evk_next = status.min_key;
                end
                else
                begin
                    wr_addr = occ_reg[IDX_W-1:0];
                    occ_inc = 1'b1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            found_reg       <= status.hit;
            read_value_reg  <= rd_value_next;
            evicted_reg     <= ev_next;
            evicted_key_reg <= evk_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    // Checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= 32'(ENTRIES))
        else $error("fill count exceeds slot count");

    a_write_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_DONE))
        else $error("slot write outside write-back");

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_reg != $past(tick_reg)) |-> (tick_reg == $past(tick_reg) + 64'd1))
        else $error("tick counter moved by more than one");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> !found)
        else $error("eviction reported on a hit");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result beat without write-back");

endmodule
